[hw/rtl/cbe_pkg.sv]
// shared constants, register codes and lane/merge types for the cursor bitmap expander
package cbe_pkg;

	localparam int MAX_CURSOR_SIZE       = 64;
	localparam int SCANLINE_PAD_BITS_DEF = 32;
	localparam int MAX_SOURCE_SIZE_DEF   = 1024;

	localparam int LANES      = 8;
	localparam int PIX_W      = 8;
	localparam int SIZE_REG_W = 11;
	localparam int HOT_W      = 10;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 11;
	localparam int WIN_W      = $clog2(MAX_CURSOR_SIZE + 1);
	localparam int ROW_W      = $clog2(MAX_CURSOR_SIZE);
	localparam int LANE_W     = $clog2(LANES);
	localparam int COUNT_W    = $clog2(LANES + 1);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_HOT_X  = 3'd2,
		REG_HOT_Y  = 3'd3,
		REG_FG     = 3'd4,
		REG_BG     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic             valid;
		logic             opaque;
		logic [PIX_W-1:0] pixel;
	} lane_t;

	typedef struct packed {
		logic                   emit;
		logic [LANES*PIX_W-1:0] pixel_bytes;
		logic [LANES-1:0]       opaque_bits;
		logic [LANE_W-1:0]      first_lane;
		logic [COUNT_W-1:0]     valid_count;
		logic [LANE_W-1:0]      last_lane;
	} merge_t;

endpackage

[hw/rtl/cbe_if.sv]
// request channel interfaces: configuration writes, bitmap byte pairs, pixel results
interface cbe_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cbe_pkg::CFG_ADDR_W-1:0]   addr;
	logic [cbe_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

interface cbe_in_if;
	logic                        valid;
	logic                        ready;
	logic [cbe_pkg::PIX_W-1:0]   source_byte;
	logic [cbe_pkg::PIX_W-1:0]   mask_byte;
	logic                        image_start;
	modport source (output valid, source_byte, mask_byte, image_start, input ready);
	modport sink (input valid, source_byte, mask_byte, image_start, output ready);
endinterface

interface cbe_out_if;
	logic                                          valid;
	logic                                          ready;
	logic [cbe_pkg::LANES*cbe_pkg::PIX_W-1:0]      pixel_bytes;
	logic [cbe_pkg::LANES-1:0]                     opaque_bits;
	logic [cbe_pkg::LANE_W-1:0]                    first_lane;
	logic [cbe_pkg::COUNT_W-1:0]                   valid_count;
	logic [cbe_pkg::ROW_W-1:0]                     out_row;
	logic [cbe_pkg::ROW_W-1:0]                     out_col;
	logic [cbe_pkg::WIN_W-1:0]                     hot_offset_x;
	logic [cbe_pkg::WIN_W-1:0]                     hot_offset_y;
	logic                                          image_done;
	modport source (output valid, pixel_bytes, opaque_bits, first_lane, valid_count, out_row,
		out_col, hot_offset_x, hot_offset_y, image_done, input ready);
	modport sink (input valid, pixel_bytes, opaque_bits, first_lane, valid_count, out_row,
		out_col, hot_offset_x, hot_offset_y, image_done, output ready);
endinterface

[hw/rtl/cursor_bitmap_expand_unit.sv]
// top level: monochrome cursor bitmap to 8-bit pixel expander with hotspot window crop
// an accepted byte-pair request that yields pixels is written into the output register at the end of its cycle
// throughput: 1 request per cycle; a request flagged image_start is held
//   while the shared restoring divider finds the x then y window start
// one output register: while its result waits unread, no new request is taken
// reset (arst_n low): width and height 1, hotspot 0, colors 0, counters and window starts 0
module cursor_bitmap_expand_unit #(
	parameter int SCANLINE_PAD_BITS = cbe_pkg::SCANLINE_PAD_BITS_DEF,
	parameter int MAX_SOURCE_SIZE   = cbe_pkg::MAX_SOURCE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cbe_cfg_if.sink     cfg,
	cbe_in_if.sink      bitmap,
	cbe_out_if.source   pixels
);
	// one width for sizes, row counts and bit positions, incl. padding and raw register values
	localparam int XW    = $clog2(MAX_SOURCE_SIZE + 2*SCANLINE_PAD_BITS + 2048);
	localparam int BPW   = SCANLINE_PAD_BITS / 8;
	localparam int BIW_W = (BPW > 1) ? $clog2(BPW) : 1;
	localparam int MW    = cbe_pkg::WIN_W;
	localparam int RW    = cbe_pkg::ROW_W;
	localparam int LANES = cbe_pkg::LANES;
	localparam int MAXC  = cbe_pkg::MAX_CURSOR_SIZE;

	typedef enum logic [1:0] {S_RUN, S_DIVX, S_DIVY} state_t;

	// configuration registers
	logic [cbe_pkg::SIZE_REG_W-1:0] width_q;
	logic [cbe_pkg::SIZE_REG_W-1:0] height_q;
	logic [cbe_pkg::HOT_W-1:0]      hot_x_q;
	logic [cbe_pkg::HOT_W-1:0]      hot_y_q;
	logic [cbe_pkg::PIX_W-1:0]      fg_q;
	logic [cbe_pkg::PIX_W-1:0]      bg_q;

	// walk state
	state_t            state_q;
	logic              primed_q;
	logic [XW-1:0]     row_q;
	logic [XW-1:0]     bit_q;
	logic [XW-1:0]     word_q;
	logic [BIW_W-1:0]  biw_q;
	logic [XW-1:0]     wxs_q;
	logic [XW-1:0]     wys_q;
	logic              out_valid_q;

	logic              cfg_fire;
	logic              out_free;
	logic              accept;
	logic              restart;
	logic              trigger;
	logic [XW-1:0]     w_eff;
	logic [XW-1:0]     h_eff;
	logic [MW-1:0]     ww;
	logic [MW-1:0]     wh;
	logic [XW-1:0]     cur_row;
	logic [XW-1:0]     cur_bit;
	logic [XW-1:0]     cur_word;
	logic [BIW_W-1:0]  cur_biw;
	logic              past_end;
	logic              row_ok;
	logic              byte_ok;
	logic              last_w;
	logic [XW-1:0]     bound;
	logic              row_end;
	logic [XW-1:0]     orow;
	logic [XW-1:0]     first_pos;
	logic [XW-1:0]     last_end;
	logic [XW-1:0]     win_end;
	logic              done_hit;
	logic [XW-1:0]     hx_ext;
	logic [XW-1:0]     hy_ext;
	logic [XW-1:0]     hx_diff;
	logic [XW-1:0]     hy_diff;
	logic [MW-1:0]     hx_off;
	logic [MW-1:0]     hy_off;

	// divider hookup
	logic                        div_start;
	logic [XW-1:0]               div_size;
	logic [cbe_pkg::HOT_W-1:0]   div_hot;
	logic                        div_done;
	logic [XW-1:0]               div_res;

	cbe_pkg::lane_t   lanes [LANES];
	cbe_pkg::merge_t  merged;

	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	// register file, taken whenever the write channel requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cbe_pkg::SIZE_REG_W'(1);
			height_q <= cbe_pkg::SIZE_REG_W'(1);
			hot_x_q  <= '0;
			hot_y_q  <= '0;
			fg_q     <= '0;
			bg_q     <= '0;
		end else if (cfg_fire) begin
			case (cfg.addr)
				cbe_pkg::REG_WIDTH:  width_q  <= cfg.data;
				cbe_pkg::REG_HEIGHT: height_q <= cfg.data;
				cbe_pkg::REG_HOT_X:  hot_x_q  <= cfg.data[cbe_pkg::HOT_W-1:0];
				cbe_pkg::REG_HOT_Y:  hot_y_q  <= cfg.data[cbe_pkg::HOT_W-1:0];
				cbe_pkg::REG_FG:     fg_q     <= cfg.data[cbe_pkg::PIX_W-1:0];
				cbe_pkg::REG_BG:     bg_q     <= cfg.data[cbe_pkg::PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective sizes: zero counts as one, clipped at the largest source
	always_comb begin
		if (width_q == '0) begin
			w_eff = XW'(1);
		end else if (XW'(width_q) > XW'(MAX_SOURCE_SIZE)) begin
			w_eff = XW'(MAX_SOURCE_SIZE);
		end else begin
			w_eff = XW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = XW'(1);
		end else if (XW'(height_q) > XW'(MAX_SOURCE_SIZE)) begin
			h_eff = XW'(MAX_SOURCE_SIZE);
		end else begin
			h_eff = XW'(height_q);
		end
		ww = (w_eff < XW'(MAXC)) ? w_eff[MW-1:0] : MW'(MAXC);
		wh = (h_eff < XW'(MAXC)) ? h_eff[MW-1:0] : MW'(MAXC);
	end

	// handshake: an image start request waits until both window starts are fresh
	assign out_free     = !out_valid_q || pixels.ready;
	assign bitmap.ready = (state_q == S_RUN) && out_free && (!bitmap.image_start || primed_q);
	assign accept       = bitmap.valid && bitmap.ready;
	assign restart      = accept && bitmap.image_start;
	assign trigger      = (state_q == S_RUN) && bitmap.valid && bitmap.image_start &&
		!primed_q && !cfg.valid;

	assign div_start = trigger || ((state_q == S_DIVX) && div_done && !cfg.valid);
	assign div_size  = (state_q == S_RUN) ? w_eff : h_eff;
	assign div_hot   = (state_q == S_RUN) ? hot_x_q : hot_y_q;

	cbe_div #(.XW(XW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.size   (div_size),
		.hot    (div_hot),
		.done   (div_done),
		.result (div_res)
	);

	// position of the current byte; an image start restarts the walk at zero
	always_comb begin
		cur_row  = restart ? '0 : row_q;
		cur_bit  = restart ? '0 : bit_q;
		cur_word = restart ? '0 : word_q;
		cur_biw  = restart ? '0 : biw_q;
		past_end = cur_row >= h_eff;
		orow     = cur_row - wys_q;
		row_ok   = (cur_row >= wys_q) && (orow < XW'(wh));
		// byte lies inside the padded row when its pad word starts left of the image edge
		byte_ok  = cur_word < w_eff;
		last_w   = cur_biw == BIW_W'(BPW - 1);
		bound    = last_w ? cur_word + XW'(SCANLINE_PAD_BITS) : cur_word;
		row_end  = bound >= w_eff;
	end

	// eight lanes, lane i takes source bit 7-i
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		cbe_lane #(.XW(XW), .LANE(g)) u_lane (
			.bit_base  (cur_bit),
			.win_start (wxs_q),
			.win_size  (ww),
			.src_bit   (bitmap.source_byte[LANES-1-g]),
			.mask_bit  (bitmap.mask_byte[LANES-1-g]),
			.fg        (fg_q),
			.bg        (bg_q),
			.lane      (lanes[g])
		);
	end

	cbe_merge u_merge (
		.gate   (!past_end && row_ok && byte_ok),
		.lanes  (lanes),
		.merged (merged)
	);

	// window column, end-of-image test and hotspot offsets
	always_comb begin
		first_pos = cur_bit + XW'(merged.first_lane) - wxs_q;
		last_end  = cur_bit + XW'(merged.last_lane) + XW'(1);
		win_end   = wxs_q + XW'(ww);
		done_hit  = (orow + XW'(1) == XW'(wh)) && (last_end == win_end);
		hx_ext    = XW'(hot_x_q);
		hy_ext    = XW'(hot_y_q);
		hx_diff   = (hx_ext >= wxs_q) ? hx_ext - wxs_q : '0;
		hy_diff   = (hy_ext >= wys_q) ? hy_ext - wys_q : '0;
		hx_off    = (hx_diff > XW'(MAXC)) ? MW'(MAXC) : hx_diff[MW-1:0];
		hy_off    = (hy_diff > XW'(MAXC)) ? MW'(MAXC) : hy_diff[MW-1:0];
	end

	// sequencer, walk counters and latched window starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RUN;
			primed_q <= 1'b0;
			row_q    <= '0;
			bit_q    <= '0;
			word_q   <= '0;
			biw_q    <= '0;
			wxs_q    <= '0;
			wys_q    <= '0;
		end else begin
			if (cfg_fire) begin
				// any register change, also mid-division: work the windows out again
				state_q  <= S_RUN;
				primed_q <= 1'b0;
			end else begin
				case (state_q)
					S_RUN: begin
						if (trigger) begin
							state_q <= S_DIVX;
						end else if (restart) begin
							// fresh windows are used up by the image start
							primed_q <= 1'b0;
						end
					end
					S_DIVX: begin
						if (div_done) begin
							wxs_q   <= div_res;
							state_q <= S_DIVY;
						end
					end
					S_DIVY: begin
						if (div_done) begin
							wys_q    <= div_res;
							primed_q <= 1'b1;
							state_q  <= S_RUN;
						end
					end
					default: begin
						state_q <= S_RUN;
					end
				endcase
			end
			if (accept) begin
				if (past_end) begin
					// bytes after the last row are dropped, the row count parks at the height
					row_q  <= h_eff;
					bit_q  <= cur_bit;
					word_q <= cur_word;
					biw_q  <= cur_biw;
				end else if (row_end) begin
					row_q  <= cur_row + XW'(1);
					bit_q  <= '0;
					word_q <= '0;
					biw_q  <= '0;
				end else begin
					row_q  <= cur_row;
					bit_q  <= cur_bit + XW'(8);
					biw_q  <= last_w ? '0 : cur_biw + BIW_W'(1);
					word_q <= last_w ? cur_word + XW'(SCANLINE_PAD_BITS) : cur_word;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && merged.emit) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && merged.emit) begin
			pixels.pixel_bytes  <= merged.pixel_bytes;
			pixels.opaque_bits  <= merged.opaque_bits;
			pixels.first_lane   <= merged.first_lane;
			pixels.valid_count  <= merged.valid_count;
			pixels.out_row      <= orow[RW-1:0];
			pixels.out_col      <= first_pos[RW-1:0];
			pixels.hot_offset_x <= hx_off;
			pixels.hot_offset_y <= hy_off;
			pixels.image_done   <= done_hit;
		end
	end

	assign pixels.valid = out_valid_q;

endmodule

[hw/rtl/cbe_div.sv]
// window start unit: restoring divider, one quotient bit per cycle, plus clamping
module cbe_div #(
	parameter int XW = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [XW-1:0]               size,
	input  logic [cbe_pkg::HOT_W-1:0]   hot,
	output logic                        done,
	output logic [XW-1:0]               result
);
	localparam int MW  = cbe_pkg::WIN_W;
	localparam int NW  = XW + MW;
	localparam int CNW = (MW > 1) ? $clog2(MW) : 1;
	localparam int MAXC = cbe_pkg::MAX_CURSOR_SIZE;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t          state_q;
	logic [CNW-1:0]   cnt_q;
	logic [XW-1:0]    size_q;
	logic [XW-1:0]    hot_q;
	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    dsh_q;
	logic [MW-1:0]    quo_q;

	logic [XW-1:0]    hot_ext;
	logic [XW-1:0]    hot_clip;
	logic [NW-1:0]    numer;
	logic             take;
	logic [XW:0]      sum;
	logic [XW:0]      lifted;
	logic [XW:0]      limit;
	logic [XW-1:0]    final_val;

	always_comb begin
		hot_ext  = XW'(hot);
		hot_clip = (hot_ext >= size) ? size - XW'(1) : hot_ext;
		numer    = NW'(size - hot_clip) * NW'(MAXC);
		take     = rem_q >= dsh_q;
		sum      = (XW+1)'(hot_q) + (XW+1)'(quo_q);
		lifted   = (sum >= (XW+1)'(MAXC)) ? sum - (XW+1)'(MAXC) : '0;
		limit    = (XW+1)'(size_q) - (XW+1)'(MAXC);
		if (size_q <= XW'(MAXC)) begin
			final_val = '0;
		end else if (lifted > limit) begin
			final_val = limit[XW-1:0];
		end else begin
			final_val = lifted[XW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			size_q  <= '0;
			hot_q   <= '0;
			rem_q   <= '0;
			dsh_q   <= '0;
			quo_q   <= '0;
			done    <= 1'b0;
			result  <= '0;
		end else if (start) begin
			state_q <= D_RUN;
			cnt_q   <= CNW'(MW - 1);
			size_q  <= size;
			hot_q   <= hot_clip;
			rem_q   <= numer;
			dsh_q   <= NW'(size) << (MW - 1);
			quo_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				D_IDLE: begin
				end
				D_RUN: begin
					if (take) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q <= {quo_q[MW-2:0], take};
					dsh_q <= dsh_q >> 1;
					if (cnt_q == '0) begin
						state_q <= D_FIN;
					end else begin
						cnt_q <= cnt_q - CNW'(1);
					end
				end
				D_FIN: begin
					result  <= final_val;
					done    <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/cbe_lane.sv]
// one pixel lane: window test and pixel expansion for a single source bit
module cbe_lane #(
	parameter int XW   = 12,
	parameter int LANE = 0
) (
	input  logic [XW-1:0]                 bit_base,
	input  logic [XW-1:0]                 win_start,
	input  logic [cbe_pkg::WIN_W-1:0]     win_size,
	input  logic                          src_bit,
	input  logic                          mask_bit,
	input  logic [cbe_pkg::PIX_W-1:0]     fg,
	input  logic [cbe_pkg::PIX_W-1:0]     bg,
	output cbe_pkg::lane_t                lane
);
	logic [XW-1:0] px;
	logic [XW-1:0] rel;

	always_comb begin
		px         = bit_base + XW'(LANE);
		rel        = px - win_start;
		lane.valid = (px >= win_start) && (rel < XW'(win_size));
		lane.opaque = lane.valid && mask_bit;
		if (lane.opaque) begin
			lane.pixel = src_bit ? fg : bg;
		end else begin
			lane.pixel = '0;
		end
	end

endmodule

[hw/rtl/cbe_merge.sv]
// merge stage: packs lane pixels and finds first, last and count of valid lanes
module cbe_merge (
	input  logic                  gate,
	input  cbe_pkg::lane_t        lanes [cbe_pkg::LANES],
	output cbe_pkg::merge_t       merged
);
	localparam int LANES = cbe_pkg::LANES;
	localparam int PW    = cbe_pkg::PIX_W;

	always_comb begin
		merged = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (lanes[i].valid) begin
				merged.first_lane = cbe_pkg::LANE_W'(i);
			end
		end
		for (int i = 0; i < LANES; i++) begin
			if (lanes[i].valid) begin
				merged.last_lane   = cbe_pkg::LANE_W'(i);
				merged.valid_count = merged.valid_count + cbe_pkg::COUNT_W'(1);
			end
			merged.pixel_bytes[i*PW +: PW] = lanes[i].pixel;
			merged.opaque_bits[i]          = lanes[i].opaque;
		end
		merged.emit = gate && (merged.valid_count != '0);
	end

endmodule

[hw/rtl/cbe_checker.sv]
// port-level checker for the cursor bitmap expander, bound to the top level
module cbe_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic         in_valid,
	input logic         in_ready,
	input logic         in_start,
	input logic         out_valid,
	input logic         out_ready,
	input logic [105:0] out_payload
);

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a waiting result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload))
		else $error("result changed while stalled");

	// every new result comes from a request taken in the previous cycle
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without a request");

	// a register write forces the window starts to be recomputed before an image start
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !(in_valid && in_ready && in_start))
		else $error("image start taken right after a register write");

endmodule

bind cursor_bitmap_expand_unit cbe_checker u_cbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready),
	.in_valid    (bitmap.valid),
	.in_ready    (bitmap.ready),
	.in_start    (bitmap.image_start),
	.out_valid   (pixels.valid),
	.out_ready   (pixels.ready),
	.out_payload ({pixels.pixel_bytes, pixels.opaque_bits, pixels.first_lane,
		pixels.valid_count, pixels.out_row, pixels.out_col, pixels.hot_offset_x,
		pixels.hot_offset_y, pixels.image_done})
);
